FILE: src/brf_pkg.sv
package brf_pkg;

    // Access commands.
    localparam logic [2:0] CMD_RD_BYTE = 3'd0;
    localparam logic [2:0] CMD_WR_BYTE = 3'd1;
    localparam logic [2:0] CMD_RD_BIT  = 3'd2;
    localparam logic [2:0] CMD_WR_BIT  = 3'd3;
    localparam logic [2:0] CMD_WR_HI   = 3'd4;
    localparam logic [2:0] CMD_WR_LO   = 3'd5;

    // Result status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_UNIMPL = 2'd2;

    localparam logic [7:0] STATUS_ADDR  = 8'h03;
    localparam logic [7:0] UNIMPL_ADDR  = 8'h07;
    localparam int         BANK_BIT     = 5;
    localparam logic [7:0] STATUS_RESET = 8'h18;

    typedef struct packed {
        logic [2:0] cmd;
        logic [2:0] bit_index;
        logic [7:0] data;
    } t_op;

    typedef struct packed {
        logic       we;
        logic [7:0] new_value;
        logic [7:0] read_data;
    } t_res;

    // Addresses of bank 1 that map onto bank 0 storage.
    function automatic logic is_alias(input logic [7:0] addr);
        return (addr == 8'd2) || (addr == 8'd3) || (addr == 8'd4) ||
               (addr == 8'd10) || (addr == 8'd11);
    endfunction

    // Power-on contents of one entry.
    function automatic logic [7:0] reset_value(input logic bank1, input logic [7:0] addr);
        logic [7:0] v;
        v = 8'h00;
        if (!bank1) begin
            if (addr == STATUS_ADDR) begin
                v = STATUS_RESET;
            end
        end else begin
            if (addr == 8'd1 || addr == 8'd6) begin
                v = 8'hFF;
            end else if (addr == 8'd5) begin
                v = 8'h1F;
            end
        end
        return v;
    endfunction

endpackage

FILE: src/brf_ram.sv
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 80
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/brf_alu.sv
module brf_alu import brf_pkg::*; (
    input  t_op        i_op,
    input  logic [7:0] i_old,
    output t_res       o_res
);

    always_comb begin
        o_res.we        = 1'b0;
        o_res.new_value = i_old;
        o_res.read_data = 8'h00;
        case (i_op.cmd)
            CMD_RD_BYTE: o_res.read_data = i_old;
            CMD_WR_BYTE: begin
                o_res.we        = 1'b1;
                o_res.new_value = i_op.data;
            end
            CMD_RD_BIT: o_res.read_data = {7'd0, i_old[i_op.bit_index]};
            CMD_WR_BIT: begin
                o_res.we = 1'b1;
                o_res.new_value[i_op.bit_index] = i_op.data[0];
            end
            CMD_WR_HI: begin
                o_res.we        = 1'b1;
                o_res.new_value = {i_op.data[3:0], i_old[3:0]};
            end
            CMD_WR_LO: begin
                o_res.we        = 1'b1;
                o_res.new_value = {i_old[7:4], i_op.data[3:0]};
            end
            default: ;
        endcase
    end

endmodule

FILE: src/banked_register_file.sv
// A request is captured when accepted; its result beat is registered when the access
// completes, which waits while the result register still holds an unread beat. One access
// at a time: the RAM read of the entry comes first, then its modify and write-back.
// Reset: synchronous, active low. Per-entry valid bits are cleared at once, so the block
// accepts requests as soon as reset is released; no clearing pass is run.
module banked_register_file import brf_pkg::*; #(
    parameter int REGS_PER_BANK = 80
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_cmd,
    input  logic [7:0] i_address,
    input  logic       i_use_given_bank,
    input  logic       i_bank,
    input  logic [2:0] i_bit_index,
    input  logic [7:0] i_data,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_read_data,
    output logic [1:0] o_status
);

    localparam int AW = $clog2(REGS_PER_BANK);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    // Control state.
    logic                     r_state, n_state;
    logic                     r_rp0;
    logic [REGS_PER_BANK-1:0] r_vld0, r_vld1;
    logic                     r_out_valid;

    // Captured request.
    t_op                      r_op;
    logic [AW-1:0]            r_idx;
    logic [7:0]               r_addr;
    logic                     r_b1;
    logic [1:0]               r_st;
    logic                     r_ok;

    // Result register.
    logic [7:0]               r_rd;
    logic [1:0]               r_ost;

    logic                     w_accept;
    logic                     w_done;
    logic [1:0]               w_st;
    logic                     w_cmd_ok;
    logic                     w_sel_bank;
    logic [AW-1:0]            w_raddr;
    logic [7:0]               w_rdata0, w_rdata1;
    logic [7:0]               w_old;
    logic                     w_vld;
    t_res                     w_res;
    logic                     w_we0, w_we1;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    // The access completes once the result register can take the beat.
    assign w_done   = (r_state == S_EXEC) && (!r_out_valid || i_ready);

    // Classify the request. Unknown commands report ok and touch nothing.
    always_comb begin
        w_cmd_ok = (i_cmd <= CMD_WR_LO);
        if (!w_cmd_ok) begin
            w_st = ST_OK;
        end else if (i_address > 8'(REGS_PER_BANK - 1)) begin
            w_st = ST_RANGE;
        end else if (i_address == UNIMPL_ADDR) begin
            w_st = ST_UNIMPL;
        end else begin
            w_st = ST_OK;
        end
    end

    // Bit and nibble operations always follow the status bank bit; aliased
    // addresses always land in bank 0.
    assign w_sel_bank = ((i_cmd <= CMD_WR_BYTE) && i_use_given_bank) ? i_bank : r_rp0;

    // Hold the read address during a stall so the RAM data stays put.
    assign w_raddr = (r_state == S_IDLE) ? i_address[AW-1:0] : r_idx;

    brf_ram #(.WIDTH(8), .DEPTH(REGS_PER_BANK)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (w_we0),
        .i_waddr (r_idx),
        .i_wdata (w_res.new_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata0)
    );

    brf_ram #(.WIDTH(8), .DEPTH(REGS_PER_BANK)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (w_we1),
        .i_waddr (r_idx),
        .i_wdata (w_res.new_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata1)
    );

    // An entry that was never written reads as its power-on value.
    assign w_vld = r_b1 ? r_vld1[r_idx] : r_vld0[r_idx];
    assign w_old = w_vld ? (r_b1 ? w_rdata1 : w_rdata0) : reset_value(r_b1, r_addr);

    brf_alu u_alu (
        .i_op  (r_op),
        .i_old (w_old),
        .o_res (w_res)
    );

    assign w_we0 = w_done && r_ok && w_res.we && !r_b1;
    assign w_we1 = w_done && r_ok && w_res.we && r_b1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rp0       <= STATUS_RESET[BANK_BIT];
            r_vld0      <= '0;
            r_vld1      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_we0) begin
                r_vld0[r_idx] <= 1'b1;
                // Mirror the bank select bit of the status register.
                if (r_idx == AW'(STATUS_ADDR)) begin
                    r_rp0 <= w_res.new_value[BANK_BIT];
                end
            end
            if (w_we1) begin
                r_vld1[r_idx] <= 1'b1;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op.cmd       <= i_cmd;
            r_op.bit_index <= i_bit_index;
            r_op.data      <= i_data;
            r_idx          <= i_address[AW-1:0];
            r_addr         <= i_address;
            r_b1           <= w_sel_bank && !is_alias(i_address);
            r_st           <= w_st;
            r_ok           <= w_cmd_ok && (w_st == ST_OK);
        end
        if (w_done) begin
            r_rd  <= r_ok ? w_res.read_data : 8'h00;
            r_ost <= r_st;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_rd;
    assign o_status    = r_ost;

    // Storage is written only while an access completes.
    a_we_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we0 || w_we1) |-> (r_state == S_EXEC && w_done))
        else $error("register write outside a completing access");

    // A flagged access never changes storage.
    a_flag_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && r_st != ST_OK) |-> !(w_we0 || w_we1))
        else $error("flagged access wrote storage");

    // The bank select mirror follows a write of the status register.
    a_rp0_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we0 && r_idx == AW'(STATUS_ADDR)) |=> (r_rp0 == $past(w_res.new_value[BANK_BIT])))
        else $error("bank select mirror out of step with status register");

    // No new request is taken while an access is in flight.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> !o_ready)
        else $error("request accepted during an access");

endmodule

FILE: tb/sv/brf_checker.sv
`timescale 1ns / 1ps

module brf_checker import brf_pkg::*; #(
    parameter int REGS_PER_BANK = 80
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic       i_req_ready,
    input  logic [2:0] i_cmd,
    input  logic [7:0] i_address,
    input  logic       i_use_given_bank,
    input  logic       i_bank,
    input  logic [2:0] i_bit_index,
    input  logic [7:0] i_data,
    input  logic       i_rsp_valid,
    input  logic       i_rsp_ready,
    input  logic [7:0] i_read_data,
    input  logic [1:0] i_status,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);

    localparam int REPORT_LIMIT = 10;
    localparam int AW           = $clog2(REGS_PER_BANK);

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] status;
    } t_reply;

    logic [7:0] low_bank  [REGS_PER_BANK];
    logic [7:0] high_bank [REGS_PER_BANK];
    t_reply     awaited_replies[$];

    // Bank 1 addresses that land on bank 0 storage.
    function automatic logic shared_with_low_bank(input logic [7:0] addr);
        case (addr)
            8'd2, STATUS_ADDR, 8'd4, 8'd10, 8'd11: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    task automatic load_power_on();
        for (int a = 0; a < REGS_PER_BANK; a++) begin
            low_bank[a]  = 8'h00;
            high_bank[a] = 8'h00;
        end
        low_bank[AW'(STATUS_ADDR)] = STATUS_RESET;
        high_bank[1] = 8'hFF;
        high_bank[5] = 8'h1F;
        high_bank[6] = 8'hFF;
    endtask

    // Applies one access to the register copy and returns the reply it should give.
    function automatic t_reply predict_access(input logic [2:0] cmd, input logic [7:0] addr,
                                              input logic use_bank, input logic bank,
                                              input logic [2:0] bit_pos,
                                              input logic [7:0] data);
        t_reply        r;
        logic          upper;
        logic [AW-1:0] idx;
        logic [7:0]    cur;
        logic [7:0]    nxt;
        r = '0;
        if (cmd > CMD_WR_LO) begin
            return r;
        end
        if (addr > REGS_PER_BANK - 1) begin
            r.status = ST_RANGE;
            return r;
        end
        if (addr == UNIMPL_ADDR) begin
            r.status = ST_UNIMPL;
            return r;
        end
        idx   = AW'(addr);
        upper = low_bank[AW'(STATUS_ADDR)][BANK_BIT];
        if ((cmd == CMD_RD_BYTE || cmd == CMD_WR_BYTE) && use_bank) begin
            upper = bank;
        end
        upper = upper && !shared_with_low_bank(addr);
        cur = upper ? high_bank[idx] : low_bank[idx];
        nxt = cur;
        case (cmd)
            CMD_RD_BYTE: r.read_data = cur;
            CMD_WR_BYTE: nxt = data;
            CMD_RD_BIT:  r.read_data = {7'd0, cur[bit_pos]};
            CMD_WR_BIT:  nxt[bit_pos] = data[0];
            CMD_WR_HI:   nxt = {data[3:0], cur[3:0]};
            default:     nxt = {cur[7:4], data[3:0]};
        endcase
        if (upper) begin
            high_bank[idx] = nxt;
        end else begin
            low_bank[idx] = nxt;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            load_power_on();
            awaited_replies.delete();
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (awaited_replies.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_LIMIT) begin
                        $display("%0t: unexpected reply read_data %02h status %0d",
                                 $realtime, i_read_data, i_status);
                    end
                end else begin
                    want = awaited_replies.pop_front();
                    o_checked++;
                    if (i_read_data !== want.read_data || i_status !== want.status) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_LIMIT) begin
                            $display("%0t: reply %0d mismatch: read_data exp %02h got %02h, %s",
                                     $realtime, o_checked, want.read_data, i_read_data,
                                     $sformatf("code exp %0d got %0d", want.status, i_status));
                        end
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                awaited_replies.push_back(predict_access(i_cmd, i_address, i_use_given_bank,
                                                         i_bank, i_bit_index, i_data));
            end
        end
        o_pending = awaited_replies.size();
    end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

// Top of the register file bench. Accesses are driven at the falling edge and the
// handshakes are sampled at the rising edge; all prediction and comparison lives in
// brf_checker, which watches both channels and reports a failure count back here.
module tb_top;
    import brf_pkg::*;

    localparam int REGS           = 80;
    localparam int ITEMS          = 1450;
    // The last beats of the run go without any idling on either side.
    localparam int TAIL_ITEMS     = 200;
    // After this many request beats the receiver refuses replies for a long stretch,
    // so the block backs up and drops its request ready.
    localparam int LONG_HOLD_AT   = 400;
    localparam int LONG_HOLD      = 80;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;

    // The two command codes the block does not define.
    localparam logic [2:0] CMD_BAD_LO = 3'd6;
    localparam logic [2:0] CMD_BAD_HI = 3'd7;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    logic [2:0] req_cmd      = CMD_RD_BYTE;
    logic [7:0] req_address  = 8'h00;
    logic       req_use_bank = 1'b0;
    logic       req_bank     = 1'b0;
    logic [2:0] req_bit      = 3'd0;
    logic [7:0] req_data     = 8'h00;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    logic [7:0] rsp_read_data;
    logic [1:0] rsp_status;

    int   fail_count;
    int   pending_replies;
    int   replies_checked;

    // Shared between the request driver and the reply side.
    int   n_sent         = 0;
    logic tail_calm      = 1'b0;
    logic long_hold_done = 1'b0;

    // Each side alternates between spells with and without random idling.
    int   tx_spell  = 0;
    logic tx_jitter = 1'b0;
    int   rx_spell  = 0;
    logic rx_jitter = 1'b0;
    int   rx_hold   = 0;
    int   quiet_cycles = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    banked_register_file #(
        .REGS_PER_BANK(REGS)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (req_valid),
        .o_ready         (req_ready),
        .i_cmd           (req_cmd),
        .i_address       (req_address),
        .i_use_given_bank(req_use_bank),
        .i_bank          (req_bank),
        .i_bit_index     (req_bit),
        .i_data          (req_data),
        .o_valid         (rsp_valid),
        .i_ready         (rsp_ready),
        .o_read_data     (rsp_read_data),
        .o_status        (rsp_status)
    );

    brf_checker #(
        .REGS_PER_BANK(REGS)
    ) u_access_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_req_valid     (req_valid),
        .i_req_ready     (req_ready),
        .i_cmd           (req_cmd),
        .i_address       (req_address),
        .i_use_given_bank(req_use_bank),
        .i_bank          (req_bank),
        .i_bit_index     (req_bit),
        .i_data          (req_data),
        .i_rsp_valid     (rsp_valid),
        .i_rsp_ready     (rsp_ready),
        .i_read_data     (rsp_read_data),
        .i_status        (rsp_status),
        .o_fail_count    (fail_count),
        .o_pending       (pending_replies),
        .o_checked       (replies_checked)
    );

    // Offers one access and returns at the falling edge after its beat. It is always
    // entered at a falling edge, so every drive below lands on a falling edge, and
    // valid is only lowered when an idle burst is inserted between beats.
    task automatic send_access(input logic [2:0] cmd, input logic [7:0] addr,
                               input logic use_bank, input logic bank,
                               input logic [2:0] bit_pos, input logic [7:0] data);
        if (tx_spell == 0) begin
            tx_spell  = $urandom_range(10, 50);
            tx_jitter = 1'($urandom_range(0, 1));
        end else begin
            tx_spell--;
        end
        if (!tail_calm && tx_jitter && $urandom_range(0, 2) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        req_cmd      <= cmd;
        req_address  <= addr;
        req_use_bank <= use_bank;
        req_bank     <= bank;
        req_bit      <= bit_pos;
        req_data     <= data;
        req_valid    <= 1'b1;
        do @(posedge clk); while (!req_ready);
        n_sent++;
        @(negedge clk);
    endtask

    // Random access. Most beats hit implemented registers; a few go to the status
    // register (which can flip the active bank), the unimplemented slot, beyond the end
    // of the file, or use one of the undefined command codes.
    task automatic send_random_access();
        logic [2:0] cmd;
        logic [7:0] addr;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            cmd = 3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
        end else begin
            cmd = 3'($urandom_range(CMD_RD_BYTE, CMD_WR_LO));
        end
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            addr = 8'($urandom_range(REGS, 255));
        end else if (pick < 12) begin
            addr = UNIMPL_ADDR;
        end else if (pick < 20) begin
            addr = STATUS_ADDR;
        end else if (pick < 35) begin
            addr = 8'($urandom_range(0, 15));
        end else begin
            addr = 8'($urandom_range(0, REGS - 1));
        end
        send_access(cmd, addr, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
    endtask

    // Reply side. Besides short random stalls it holds off once for a long stretch
    // while requests keep coming, which fills the pipeline and stalls the request side.
    always @(negedge clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            rsp_ready <= 1'b0;
        end else if (!long_hold_done && n_sent >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            rx_hold = LONG_HOLD - 1;
            rsp_ready <= 1'b0;
        end else begin
            if (rx_spell == 0) begin
                rx_spell  = $urandom_range(10, 50);
                rx_jitter = 1'($urandom_range(0, 1));
            end else begin
                rx_spell--;
            end
            if (!tail_calm && rx_jitter && $urandom_range(0, 2) == 0) begin
                rx_hold = $urandom_range(0, 4);
                rsp_ready <= 1'b0;
            end else begin
                rsp_ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run if neither channel moves a beat for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d replies outstanding",
                         quiet_cycles, pending_replies);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. Power-on contents first: status register and the three
        // bank 1 entries that come up nonzero.
        send_access(CMD_RD_BYTE, STATUS_ADDR, 1'b0, 1'b0, 3'd0, 8'h00);
        send_access(CMD_RD_BYTE, 8'd1, 1'b1, 1'b1, 3'd0, 8'h00);
        send_access(CMD_RD_BYTE, 8'd5, 1'b1, 1'b1, 3'd0, 8'h00);
        send_access(CMD_RD_BYTE, 8'd6, 1'b1, 1'b1, 3'd0, 8'h00);
        // Unimplemented slot, the last legal address, and addresses past the end.
        send_access(CMD_WR_BYTE, UNIMPL_ADDR, 1'b0, 1'b0, 3'd0, 8'hFF);
        send_access(CMD_RD_BYTE, UNIMPL_ADDR, 1'b1, 1'b1, 3'd0, 8'h00);
        send_access(CMD_WR_BYTE, 8'h4F, 1'b1, 1'b1, 3'd0, 8'hA5);
        send_access(CMD_RD_BYTE, 8'h4F, 1'b1, 1'b1, 3'd0, 8'h00);
        send_access(CMD_RD_BYTE, 8'h50, 1'b0, 1'b0, 3'd0, 8'h00);
        send_access(CMD_WR_BYTE, 8'hFF, 1'b0, 1'b0, 3'd7, 8'hFF);
        // Aliased addresses written through bank 1 must show up in bank 0.
        send_access(CMD_WR_BYTE, 8'd2, 1'b1, 1'b1, 3'd0, 8'h5A);
        send_access(CMD_RD_BYTE, 8'd2, 1'b1, 1'b0, 3'd0, 8'h00);
        send_access(CMD_WR_BYTE, 8'd11, 1'b1, 1'b1, 3'd0, 8'h3C);
        send_access(CMD_RD_BYTE, 8'd11, 1'b1, 1'b0, 3'd0, 8'h00);
        send_access(CMD_RD_BYTE, 8'd10, 1'b1, 1'b1, 3'd0, 8'h00);
        // Switch to bank 1 through the status bank bit; only bit 0 of data counts.
        send_access(CMD_WR_BIT, STATUS_ADDR, 1'b0, 1'b0, 3'(BANK_BIT), 8'hFF);
        send_access(CMD_RD_BYTE, 8'd1, 1'b0, 1'b0, 3'd0, 8'h00);
        // Nibble and bit ops ignore the explicit bank and follow the status bit.
        send_access(CMD_WR_HI, 8'h20, 1'b1, 1'b0, 3'd0, 8'hF7);
        send_access(CMD_WR_LO, 8'h20, 1'b1, 1'b0, 3'd0, 8'hE9);
        send_access(CMD_RD_BIT, 8'h20, 1'b1, 1'b0, 3'd7, 8'h00);
        send_access(CMD_RD_BYTE, 8'h20, 1'b1, 1'b1, 3'd0, 8'h00);
        send_access(CMD_RD_BYTE, 8'h20, 1'b1, 1'b0, 3'd0, 8'h00);
        // Undefined commands, even with an out-of-range address, give a clean reply.
        send_access(CMD_BAD_LO, 8'hFF, 1'b1, 1'b1, 3'd7, 8'hFF);
        send_access(CMD_BAD_HI, 8'h00, 1'b0, 1'b0, 3'd0, 8'h00);
        // Back to bank 0 with a bit write whose data has bit 0 clear.
        send_access(CMD_WR_BIT, STATUS_ADDR, 1'b0, 1'b0, 3'(BANK_BIT), 8'hFE);
        send_access(CMD_RD_BIT, STATUS_ADDR, 1'b0, 1'b0, 3'd4, 8'h00);

        while (n_sent < ITEMS) begin
            tail_calm = (n_sent >= ITEMS - TAIL_ITEMS);
            send_random_access();
        end
        req_valid <= 1'b0;

        while (pending_replies != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d accesses: every command and both undefined codes, bank switching,",
                 n_sent);
        $display("aliases, flags, random stalls and one long back-up; %0d replies compared",
                 replies_checked);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
